FILE: sv/swsb_pkg.sv
// ----------------------------------------------------------------------------
// swsb_pkg
// Shared types and constants for the sliding window sample buffer.
// ----------------------------------------------------------------------------
package swsb_pkg;

   localparam int CHANNELS     = 6;
   localparam int WORD_W       = 32;
   localparam int IDX_W        = 7;
   localparam int TIME_W       = 48;
   localparam int STRIDE_W     = 7;
   localparam int SPAN_W       = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd62;
   localparam logic [SPAN_W-1:0]   SPAN_RESET   = 16'd2500;
   localparam logic [IDX_W-1:0]    SINCE_MAX    = 7'd127;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN   = 1'b1;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [CHANNELS-1:0] sample_type;

   // request status carried from the memory access stage to the result stage
   typedef struct packed {
      logic              read_ok;
      logic              window_ready;
      logic [TIME_W-1:0] window_start;
   } ctrl_type;

endpackage

FILE: sv/swsb_lane.sv
// ----------------------------------------------------------------------------
// swsb_lane
// One channel of the ring store: a single-port memory with registered read.
// ----------------------------------------------------------------------------
module swsb_lane
   import swsb_pkg::*;
#(
   parameter int DEPTH  = 125,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  word_type          wr_data,
   output word_type          rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/swsb_merge.sv
// ----------------------------------------------------------------------------
// swsb_merge
// Result stage: gathers the lane read words and request status into the
// output register.
// ----------------------------------------------------------------------------
module swsb_merge
   import swsb_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  ctrl_type          ctrl,
   input  sample_type        lane_data,
   output sample_type        out_data,
   output logic              out_window_ready,
   output logic [TIME_W-1:0] out_window_start
);

   sample_type        data_ff, data_in;
   logic              ready_ff;
   logic [TIME_W-1:0] start_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         data_in[c] = ctrl.read_ok ? lane_data[c] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= data_in;
         ready_ff <= ctrl.window_ready;
         start_ff <= ctrl.window_start;
      end
   end

   assign out_data         = data_ff;
   assign out_window_ready = ready_ff;
   assign out_window_start = start_ff;

endmodule

FILE: sv/sliding_window_sample_buffer.sv
// ----------------------------------------------------------------------------
// sliding_window_sample_buffer
// Ring store of six-channel samples serving overlapping analysis windows.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  mode, in_ch0..5, read_index, now
//   rsp_     out        rsp_valid/rsp_ready  out_ch0..5, window_ready, start
//   csr_     in         csr_valid/csr_ready  index, wdata
//
// A request's result passes through the registered read of the per-channel
// lane memories and then the output register; a new request is taken every
// cycle unless a stalled result holds req_ready low.
// Reset clears head, fill and since-window counts and the valid flags; memory
// contents are not cleared. A stalled result holds the memory stage, which
// in turn holds req_ready low.
// ----------------------------------------------------------------------------
module sliding_window_sample_buffer
   import swsb_pkg::*;
#(
   parameter int WINDOW_DEPTH = 125
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [WORD_W-1:0]     req_in_ch0,
   input  logic [WORD_W-1:0]     req_in_ch1,
   input  logic [WORD_W-1:0]     req_in_ch2,
   input  logic [WORD_W-1:0]     req_in_ch3,
   input  logic [WORD_W-1:0]     req_in_ch4,
   input  logic [WORD_W-1:0]     req_in_ch5,
   input  logic [IDX_W-1:0]      req_read_index,
   input  logic [TIME_W-1:0]     req_now_unix_ms,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_out_ch0,
   output logic [WORD_W-1:0]     rsp_out_ch1,
   output logic [WORD_W-1:0]     rsp_out_ch2,
   output logic [WORD_W-1:0]     rsp_out_ch3,
   output logic [WORD_W-1:0]     rsp_out_ch4,
   output logic [WORD_W-1:0]     rsp_out_ch5,
   output logic                  rsp_window_ready,
   output logic [TIME_W-1:0]     rsp_window_start_ms,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FW    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = ((AW > IDX_W) ? AW : IDX_W) + 1;

   localparam logic [AW-1:0]    HEAD_LAST = AW'(WINDOW_DEPTH - 1);
   localparam logic [FW-1:0]    FILL_FULL = FW'(WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] LAST_S    = SUM_W'(WINDOW_DEPTH - 1);

   logic [STRIDE_W-1:0] stride_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [AW-1:0]       head_ff, head_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]    since_ff, since_in;
   logic                s1_valid_ff, s1_valid_in;
   ctrl_type            s1_ctrl_ff, ctrl_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept, advance, is_push, is_read, idx_ok;
   logic [SUM_W-1:0]    idx_ext, sum, src;
   logic [AW-1:0]       mem_addr;
   sample_type          wr_sample, lane_q, out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RESET;
         span_ff   <= SPAN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STRIDE: stride_ff <= csr_wdata[STRIDE_W-1:0];
            CSR_SPAN:   span_ff   <= csr_wdata[SPAN_W-1:0];
            default:    ;
         endcase
      end
   end

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_mode == MODE_PUSH);
   assign is_read   = (req_mode == MODE_READ);

   assign idx_ext = SUM_W'(req_read_index);
   assign idx_ok  = idx_ext < DEPTH_S;
   assign sum     = SUM_W'(head_ff) + idx_ext;
   assign src     = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
   assign mem_addr = is_push ? head_ff : src[AW-1:0];

   always_comb begin
      head_in  = head_ff;
      fill_in  = fill_ff;
      since_in = since_ff;
      if (accept) begin
         if (is_push) begin
            head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
            if (fill_ff != FILL_FULL) begin
               fill_in = fill_ff + 1'b1;
            end
            if (since_ff != SINCE_MAX) begin
               since_in = since_ff + 1'b1;
            end
         end else if (idx_ok && idx_ext == LAST_S) begin
            since_in = '0;
         end
      end
   end

   always_comb begin
      ctrl_in.read_ok      = is_read && idx_ok;
      ctrl_in.window_ready = (fill_in == FILL_FULL) && (since_in >= stride_ff);
      ctrl_in.window_start = (req_now_unix_ms > TIME_W'(span_ff))
                             ? req_now_unix_ms - TIME_W'(span_ff) : '0;
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         since_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         since_ff     <= since_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl_in;
      end
   end

   assign wr_sample[0] = req_in_ch0;
   assign wr_sample[1] = req_in_ch1;
   assign wr_sample[2] = req_in_ch2;
   assign wr_sample[3] = req_in_ch3;
   assign wr_sample[4] = req_in_ch4;
   assign wr_sample[5] = req_in_ch5;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      swsb_lane #(
         .DEPTH  (WINDOW_DEPTH),
         .ADDR_W (AW)
      ) u_lane (
         .clock   (clock),
         .wr_en   (accept && is_push),
         .rd_en   (accept && is_read && idx_ok),
         .addr    (mem_addr),
         .wr_data (wr_sample[g]),
         .rd_data (lane_q[g])
      );
   end

   swsb_merge u_merge (
      .clock            (clock),
      .load             (advance),
      .ctrl             (s1_ctrl_ff),
      .lane_data        (lane_q),
      .out_data         (out_data),
      .out_window_ready (rsp_window_ready),
      .out_window_start (rsp_window_start_ms)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_ch0 = out_data[0];
   assign rsp_out_ch1 = out_data[1];
   assign rsp_out_ch2 = out_data[2];
   assign rsp_out_ch3 = out_data[3];
   assign rsp_out_ch4 = out_data[4];
   assign rsp_out_ch5 = out_data[5];

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= HEAD_LAST)
      else $error("head slot out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count above depth");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      accept && is_push && fill_ff != FILL_FULL |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count did not advance on push");

   a_since_clear: assert property (@(posedge clock) disable iff (reset)
      accept && is_read && idx_ok && idx_ext == LAST_S |=> since_ff == '0)
      else $error("since-window count not cleared by last index read");

   a_push_zero: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_ctrl_ff.read_ok |=> rsp_out_ch0 == '0 && rsp_out_ch5 == '0)
      else $error("push result carries nonzero sample data");

endmodule
